[hdl/conformal_metric_projection_macros.svh]
// assertion macros for the checker file
`ifndef CONFORMAL_METRIC_PROJECTION_MACROS_SVH
`define CONFORMAL_METRIC_PROJECTION_MACROS_SVH

// implication in the same cycle, ignored while in reset
`define CMP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication into the next cycle, ignored while in reset
`define CMP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// implication into the next cycle that also covers the reset cycles
`define CMP_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/cmp_pkg.sv]
// shared types, constants, arithmetic helpers and the sequencer program
package cmp_pkg;

  localparam int FRAC_BITS = 48;
  localparam int GUARD_W   = 49;

  // det_guard_floor register; paddr[2:0] select bytes within the 64-bit word
  localparam logic [3:0] ADDR_GUARD = 4'h0;

  localparam logic signed [63:0] FX_ONE   = 64'sh1 << FRAC_BITS;
  localparam logic signed [63:0] FX_THIRD = FX_ONE / 3;
  localparam logic signed [63:0] FX_MAX   = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] FX_MIN   = {1'b1, {63{1'b0}}};

  // floor(x / 3) for x below 2^49 as (x * DIV3_MUL) >> DIV3_SHIFT
  localparam logic [63:0] DIV3_MUL   = 64'h0002_AAAA_AAAA_AAAB;
  localparam int          DIV3_SHIFT = 51;

  localparam logic [255:0] CUBE_LIM = 256'h1 << (4 * FRAC_BITS);

  typedef struct packed {
    logic signed [63:0] metric_xx;
    logic signed [63:0] metric_xy;
    logic signed [63:0] metric_xz;
    logic signed [63:0] metric_yy;
    logic signed [63:0] metric_yz;
    logic signed [63:0] metric_zz;
    logic signed [63:0] curv_xx;
    logic signed [63:0] curv_xy;
    logic signed [63:0] curv_xz;
    logic signed [63:0] curv_yy;
    logic signed [63:0] curv_yz;
    logic signed [63:0] curv_zz;
  } item_t;

  typedef struct packed {
    logic signed [63:0] proj_metric_xx;
    logic signed [63:0] proj_metric_xy;
    logic signed [63:0] proj_metric_xz;
    logic signed [63:0] proj_metric_yy;
    logic signed [63:0] proj_metric_yz;
    logic signed [63:0] proj_metric_zz;
    logic signed [63:0] proj_curv_xx;
    logic signed [63:0] proj_curv_xy;
    logic signed [63:0] proj_curv_xz;
    logic signed [63:0] proj_curv_yy;
    logic signed [63:0] proj_curv_yz;
    logic signed [63:0] proj_curv_zz;
  } result_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic         start;
    logic [2:0]   nwords;
    logic [191:0] a;
    logic [63:0]  b;
  } mul_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_FETCH, S_EXEC, S_MWAIT, S_DIV, S_CROOT, S_CWAIT, S_PUSH
  } back_state_t;

  typedef enum logic [2:0] {OP_MUL, OP_ADD, OP_SUB, OP_FACT, OP_END} op_t;

  // register file slots; metric and curvature slots follow input order
  localparam logic [4:0] R_G0 = 5'd0;
  localparam logic [4:0] R_G1 = 5'd1;
  localparam logic [4:0] R_G2 = 5'd2;
  localparam logic [4:0] R_G3 = 5'd3;
  localparam logic [4:0] R_G4 = 5'd4;
  localparam logic [4:0] R_G5 = 5'd5;
  localparam logic [4:0] R_A0 = 5'd6;
  localparam logic [4:0] R_A1 = 5'd7;
  localparam logic [4:0] R_A2 = 5'd8;
  localparam logic [4:0] R_A3 = 5'd9;
  localparam logic [4:0] R_A4 = 5'd10;
  localparam logic [4:0] R_A5 = 5'd11;
  localparam logic [4:0] R_D  = 5'd12;
  localparam logic [4:0] R_T  = 5'd13;
  localparam logic [4:0] R_S  = 5'd14;
  localparam logic [4:0] R_U  = 5'd15;
  localparam logic [4:0] R_V  = 5'd16;
  localparam logic [4:0] R_F  = 5'd17;
  localparam logic [4:0] R_ZERO  = 5'd30;
  localparam logic [4:0] R_THIRD = 5'd31;

  localparam logic [3:0] LOAD_LAST = 4'd11;

  typedef struct packed {
    op_t        op;
    logic [4:0] dst;
    logic [4:0] src1;
    logic [4:0] src2;
    logic       out_en;
    logic [3:0] out_idx;
  } instr_t;

  function automatic logic signed [63:0] fx_add(logic signed [63:0] a,
                                                logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? FX_MIN : FX_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] fx_sub(logic signed [63:0] a,
                                                logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? FX_MIN : FX_MAX;
    return s[63:0];
  endfunction

  // sign, floor shift and saturation of a magnitude product
  function automatic logic signed [63:0] fx_mul_post(logic [127:0] p, logic neg);
    logic signed [127:0] sp;
    logic signed [127:0] sh;
    sp = neg ? (128'd0 - p) : p;
    sh = sp >>> FRAC_BITS;
    if (sh[127:63] == {65{sh[63]}}) return sh[63:0];
    return sp[127] ? FX_MIN : FX_MAX;
  endfunction

  function automatic instr_t mk(op_t op, logic [4:0] d, logic [4:0] s1,
                                logic [4:0] s2, logic oe, logic [3:0] oi);
    instr_t r;
    r.op      = op;
    r.dst     = d;
    r.src1    = s1;
    r.src2    = s2;
    r.out_en  = oe;
    r.out_idx = oi;
    return r;
  endfunction

  function automatic instr_t cmp_prog(logic [6:0] pc);
    case (pc)
      // determinant
      7'd0:  return mk(OP_MUL, R_T, R_G2, R_G2, 1'b0, 4'd0);
      7'd1:  return mk(OP_MUL, R_T, R_T, R_G3, 1'b0, 4'd0);
      7'd2:  return mk(OP_SUB, R_D, R_ZERO, R_T, 1'b0, 4'd0);
      7'd3:  return mk(OP_MUL, R_T, R_G1, R_G2, 1'b0, 4'd0);
      7'd4:  return mk(OP_MUL, R_T, R_T, R_G4, 1'b0, 4'd0);
      7'd5:  return mk(OP_ADD, R_T, R_T, R_T, 1'b0, 4'd0);
      7'd6:  return mk(OP_ADD, R_D, R_D, R_T, 1'b0, 4'd0);
      7'd7:  return mk(OP_MUL, R_T, R_G4, R_G4, 1'b0, 4'd0);
      7'd8:  return mk(OP_MUL, R_T, R_G0, R_T, 1'b0, 4'd0);
      7'd9:  return mk(OP_SUB, R_D, R_D, R_T, 1'b0, 4'd0);
      7'd10: return mk(OP_MUL, R_T, R_G1, R_G1, 1'b0, 4'd0);
      7'd11: return mk(OP_MUL, R_T, R_T, R_G5, 1'b0, 4'd0);
      7'd12: return mk(OP_SUB, R_D, R_D, R_T, 1'b0, 4'd0);
      7'd13: return mk(OP_MUL, R_T, R_G0, R_G3, 1'b0, 4'd0);
      7'd14: return mk(OP_MUL, R_T, R_T, R_G5, 1'b0, 4'd0);
      7'd15: return mk(OP_ADD, R_D, R_D, R_T, 1'b0, 4'd0);
      7'd16: return mk(OP_FACT, R_F, R_D, R_D, 1'b0, 4'd0);
      // scaled metric
      7'd17: return mk(OP_MUL, R_G0, R_G0, R_F, 1'b1, 4'd0);
      7'd18: return mk(OP_MUL, R_G1, R_G1, R_F, 1'b1, 4'd1);
      7'd19: return mk(OP_MUL, R_G2, R_G2, R_F, 1'b1, 4'd2);
      7'd20: return mk(OP_MUL, R_G3, R_G3, R_F, 1'b1, 4'd3);
      7'd21: return mk(OP_MUL, R_G4, R_G4, R_F, 1'b1, 4'd4);
      7'd22: return mk(OP_MUL, R_G5, R_G5, R_F, 1'b1, 4'd5);
      // trace
      7'd23: return mk(OP_MUL, R_T, R_A4, R_G0, 1'b0, 4'd0);
      7'd24: return mk(OP_MUL, R_T, R_T, R_G4, 1'b0, 4'd0);
      7'd25: return mk(OP_ADD, R_T, R_T, R_T, 1'b0, 4'd0);
      7'd26: return mk(OP_SUB, R_S, R_ZERO, R_T, 1'b0, 4'd0);
      7'd27: return mk(OP_MUL, R_T, R_A0, R_G3, 1'b0, 4'd0);
      7'd28: return mk(OP_MUL, R_T, R_T, R_G5, 1'b0, 4'd0);
      7'd29: return mk(OP_ADD, R_S, R_S, R_T, 1'b0, 4'd0);
      7'd30: return mk(OP_MUL, R_T, R_A5, R_G3, 1'b0, 4'd0);
      7'd31: return mk(OP_MUL, R_U, R_A3, R_G5, 1'b0, 4'd0);
      7'd32: return mk(OP_ADD, R_T, R_T, R_U, 1'b0, 4'd0);
      7'd33: return mk(OP_MUL, R_T, R_G0, R_T, 1'b0, 4'd0);
      7'd34: return mk(OP_ADD, R_S, R_S, R_T, 1'b0, 4'd0);
      7'd35: return mk(OP_MUL, R_T, R_A4, R_G1, 1'b0, 4'd0);
      7'd36: return mk(OP_MUL, R_U, R_A2, R_G3, 1'b0, 4'd0);
      7'd37: return mk(OP_SUB, R_T, R_T, R_U, 1'b0, 4'd0);
      7'd38: return mk(OP_MUL, R_U, R_A1, R_G4, 1'b0, 4'd0);
      7'd39: return mk(OP_ADD, R_T, R_T, R_U, 1'b0, 4'd0);
      7'd40: return mk(OP_MUL, R_T, R_G2, R_T, 1'b0, 4'd0);
      7'd41: return mk(OP_MUL, R_U, R_A2, R_G4, 1'b0, 4'd0);
      7'd42: return mk(OP_MUL, R_V, R_A1, R_G5, 1'b0, 4'd0);
      7'd43: return mk(OP_SUB, R_U, R_U, R_V, 1'b0, 4'd0);
      7'd44: return mk(OP_MUL, R_U, R_G1, R_U, 1'b0, 4'd0);
      7'd45: return mk(OP_ADD, R_T, R_T, R_U, 1'b0, 4'd0);
      7'd46: return mk(OP_ADD, R_T, R_T, R_T, 1'b0, 4'd0);
      7'd47: return mk(OP_ADD, R_S, R_S, R_T, 1'b0, 4'd0);
      7'd48: return mk(OP_MUL, R_T, R_G1, R_G1, 1'b0, 4'd0);
      7'd49: return mk(OP_MUL, R_T, R_A5, R_T, 1'b0, 4'd0);
      7'd50: return mk(OP_SUB, R_S, R_S, R_T, 1'b0, 4'd0);
      7'd51: return mk(OP_MUL, R_T, R_G2, R_G2, 1'b0, 4'd0);
      7'd52: return mk(OP_MUL, R_T, R_A3, R_T, 1'b0, 4'd0);
      7'd53: return mk(OP_SUB, R_S, R_S, R_T, 1'b0, 4'd0);
      7'd54: return mk(OP_MUL, R_T, R_G4, R_G4, 1'b0, 4'd0);
      7'd55: return mk(OP_MUL, R_T, R_A0, R_T, 1'b0, 4'd0);
      7'd56: return mk(OP_SUB, R_S, R_S, R_T, 1'b0, 4'd0);
      7'd57: return mk(OP_MUL, R_T, R_THIRD, R_S, 1'b0, 4'd0);
      // trace removal
      7'd58: return mk(OP_MUL, R_U, R_T, R_G0, 1'b0, 4'd0);
      7'd59: return mk(OP_SUB, R_U, R_A0, R_U, 1'b1, 4'd6);
      7'd60: return mk(OP_MUL, R_U, R_T, R_G1, 1'b0, 4'd0);
      7'd61: return mk(OP_SUB, R_U, R_A1, R_U, 1'b1, 4'd7);
      7'd62: return mk(OP_MUL, R_U, R_T, R_G2, 1'b0, 4'd0);
      7'd63: return mk(OP_SUB, R_U, R_A2, R_U, 1'b1, 4'd8);
      7'd64: return mk(OP_MUL, R_U, R_T, R_G3, 1'b0, 4'd0);
      7'd65: return mk(OP_SUB, R_U, R_A3, R_U, 1'b1, 4'd9);
      7'd66: return mk(OP_MUL, R_U, R_T, R_G4, 1'b0, 4'd0);
      7'd67: return mk(OP_SUB, R_U, R_A4, R_U, 1'b1, 4'd10);
      7'd68: return mk(OP_MUL, R_U, R_T, R_G5, 1'b0, 4'd0);
      7'd69: return mk(OP_SUB, R_U, R_A5, R_U, 1'b1, 4'd11);
      default: return mk(OP_END, R_T, R_T, R_T, 1'b0, 4'd0);
    endcase
  endfunction

endpackage

[hdl/cmp_front.sv]
// input queue that takes grid points while the sequencer is busy
module cmp_front import cmp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  item_t       item,
  input  logic        item_valid,
  output logic        item_ready,
  output queue_head_t head,
  input  logic        pop
);

  item_t      entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;

  assign item_ready = (count != 2'd2);
  assign push       = item_valid && item_ready;
  assign head.valid = (count != 2'd0);
  assign head.item  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= item;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[hdl/cmp_wmul.sv]
// word-serial multiplier: up to six 32-bit words times a 64-bit operand
module cmp_wmul import cmp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  mul_req_t     req,
  output logic         done,
  output logic [255:0] prod
);

  logic [191:0] a_r;
  logic [63:0]  b_r;
  logic [2:0]   nw;
  logic [2:0]   wi;
  logic         wj;
  logic         busy;
  logic         pp_valid;
  logic         pp_last;
  logic [63:0]  pp;
  logic [2:0]   pp_off;
  logic [31:0]  aw;
  logic [31:0]  bw;

  assign aw = a_r[{wi, 5'd0} +: 32];
  assign bw = wj ? b_r[63:32] : b_r[31:0];

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r  <= req.a;
      b_r  <= req.b;
      nw   <= req.nwords;
      wi   <= 3'd0;
      wj   <= 1'b0;
      prod <= '0;
    end else begin
      if (busy) begin
        pp      <= aw * bw;
        pp_off  <= wi + {2'd0, wj};
        pp_last <= (wi == nw - 3'd1) && wj;
        wj      <= ~wj;
        if (wj) wi <= wi + 3'd1;
      end
      if (pp_valid) begin
        prod <= prod + ({192'd0, pp} << {pp_off, 5'd0});
      end
    end
    if (rst) begin
      busy     <= 1'b0;
      pp_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      done     <= pp_valid && pp_last && !req.start;
      pp_valid <= busy && !req.start;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && wj && (wi == nw - 3'd1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[hdl/cmp_back.sv]
// sequencer that runs the projection program on the shared multiplier
module cmp_back import cmp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [GUARD_W-1:0]   guard_floor,
  input  queue_head_t          head,
  output logic                 pop,
  output result_t              result,
  output logic                 result_valid,
  input  logic                 result_ready
);

  back_state_t state;
  back_state_t state_next;

  logic signed [63:0] rf [32];
  logic signed [63:0] rd1;
  logic signed [63:0] rd2;
  logic [4:0]         s1_r;
  logic [4:0]         s2_r;
  logic [6:0]         pc;
  logic [3:0]         ld_cnt;
  logic               mul_neg;
  logic [63:0]        det_r;
  logic [63:0]        y;
  logic [5:0]         cbit;
  logic [1:0]         cstage;
  logic [191:0]       p_r;
  logic signed [63:0] out_buf [12];

  instr_t             cur;
  logic signed [63:0] op1;
  logic signed [63:0] op2;
  logic [63:0]        abs1;
  logic [63:0]        abs2;
  logic signed [63:0] dfix;
  logic [63:0]        dev;
  logic               guard_hit;
  logic [63:0]        cand;
  logic [63:0]        ynew;
  logic [63:0]        quot;
  logic signed [63:0] load_word;
  logic               push_ok;
  logic               rf_we;
  logic [4:0]         rf_waddr;
  logic signed [63:0] rf_wdata;
  logic               instr_done;
  mul_req_t           mreq;
  logic               mdone;
  logic [255:0]       mprod;

  cmp_wmul u_wmul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .done (mdone),
    .prod (mprod)
  );

  assign cur = cmp_prog(pc);
  assign op1 = (s1_r == R_ZERO) ? 64'sd0 : (s1_r == R_THIRD) ? FX_THIRD : rd1;
  assign op2 = (s2_r == R_ZERO) ? 64'sd0 : (s2_r == R_THIRD) ? FX_THIRD : rd2;
  assign abs1 = op1[63] ? (64'd0 - op1) : op1;
  assign abs2 = op2[63] ? (64'd0 - op2) : op2;

  // non-positive determinant becomes one, so the linear factor applies
  assign dfix = (op1 <= 64'sd0) ? FX_ONE : op1;
  assign dev  = (dfix >= FX_ONE) ? (dfix - FX_ONE) : (FX_ONE - dfix);
  assign guard_hit = dev < {{(64-GUARD_W){1'b0}}, guard_floor};

  assign cand = y | (64'd1 << cbit);
  assign ynew = (mprod <= CUBE_LIM) ? cand : y;
  assign quot = mprod[DIV3_SHIFT +: 64];
  assign push_ok = !result_valid || result_ready;

  always_comb begin
    case (ld_cnt)
      4'd0:  load_word = head.item.metric_xx;
      4'd1:  load_word = head.item.metric_xy;
      4'd2:  load_word = head.item.metric_xz;
      4'd3:  load_word = head.item.metric_yy;
      4'd4:  load_word = head.item.metric_yz;
      4'd5:  load_word = head.item.metric_zz;
      4'd6:  load_word = head.item.curv_xx;
      4'd7:  load_word = head.item.curv_xy;
      4'd8:  load_word = head.item.curv_xz;
      4'd9:  load_word = head.item.curv_yy;
      4'd10: load_word = head.item.curv_yz;
      default: load_word = head.item.curv_zz;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (head.valid) state_next = S_LOAD;
      S_LOAD:  if (ld_cnt == LOAD_LAST) state_next = S_FETCH;
      S_FETCH: state_next = S_EXEC;
      S_EXEC: begin
        case (cur.op)
          OP_MUL:  state_next = S_MWAIT;
          OP_FACT: state_next = guard_hit ? S_DIV : S_CROOT;
          OP_END:  state_next = S_PUSH;
          default: state_next = S_FETCH;
        endcase
      end
      S_MWAIT: if (mdone) state_next = S_FETCH;
      S_DIV:   if (mdone) state_next = S_FETCH;
      S_CROOT: state_next = S_CWAIT;
      S_CWAIT: begin
        if (mdone) begin
          state_next = (cstage == 2'd2 && cbit == 6'd0) ? S_FETCH : S_CROOT;
        end
      end
      S_PUSH:  if (push_ok) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rf_we       = 1'b0;
    rf_waddr    = cur.dst;
    rf_wdata    = fx_add(op1, op2);
    instr_done  = 1'b0;
    pop         = 1'b0;
    mreq.start  = 1'b0;
    mreq.nwords = 3'd2;
    mreq.a      = {128'd0, abs1};
    mreq.b      = abs2;
    case (state)
      S_LOAD: begin
        rf_we    = 1'b1;
        rf_waddr = {1'b0, ld_cnt};
        rf_wdata = load_word;
        pop      = (ld_cnt == LOAD_LAST);
      end
      S_EXEC: begin
        case (cur.op)
          OP_MUL: mreq.start = 1'b1;
          OP_ADD: begin
            rf_we      = 1'b1;
            instr_done = 1'b1;
          end
          OP_SUB: begin
            rf_we      = 1'b1;
            rf_wdata   = fx_sub(op1, op2);
            instr_done = 1'b1;
          end
          OP_FACT: begin
            mreq.start = guard_hit;
            mreq.a     = {128'd0, {(64-GUARD_W){1'b0}}, guard_floor};
            mreq.b     = DIV3_MUL;
          end
          default: ;
        endcase
      end
      S_MWAIT: begin
        rf_we      = mdone;
        rf_wdata   = fx_mul_post(mprod[127:0], mul_neg);
        instr_done = mdone;
      end
      S_DIV: begin
        rf_we      = mdone;
        rf_wdata   = FX_ONE - quot;
        instr_done = mdone;
      end
      S_CROOT: begin
        mreq.start = 1'b1;
        case (cstage)
          2'd0: begin
            mreq.a = {128'd0, cand};
            mreq.b = cand;
          end
          2'd1: begin
            mreq.nwords = 3'd4;
            mreq.a      = p_r;
            mreq.b      = cand;
          end
          default: begin
            mreq.nwords = 3'd6;
            mreq.a      = p_r;
            mreq.b      = det_r;
          end
        endcase
      end
      S_CWAIT: begin
        rf_we      = mdone && cstage == 2'd2 && cbit == 6'd0;
        rf_wdata   = ynew;
        instr_done = rf_we;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_waddr] <= rf_wdata;
    rd1  <= rf[cur.src1];
    rd2  <= rf[cur.src2];
    s1_r <= cur.src1;
    s2_r <= cur.src2;
    if (instr_done && cur.out_en) out_buf[cur.out_idx] <= rf_wdata;
    if (state == S_EXEC && cur.op == OP_MUL) mul_neg <= op1[63] ^ op2[63];
    if (state == S_EXEC && cur.op == OP_FACT) begin
      det_r  <= dfix;
      y      <= 64'd0;
      cbit   <= 6'd62;
      cstage <= 2'd0;
    end
    if (state == S_CWAIT && mdone) begin
      if (cstage != 2'd2) begin
        p_r    <= mprod[191:0];
        cstage <= cstage + 2'd1;
      end else begin
        y      <= ynew;
        cstage <= 2'd0;
        cbit   <= cbit - 6'd1;
      end
    end
    if (state == S_PUSH && push_ok) begin
      result.proj_metric_xx <= out_buf[0];
      result.proj_metric_xy <= out_buf[1];
      result.proj_metric_xz <= out_buf[2];
      result.proj_metric_yy <= out_buf[3];
      result.proj_metric_yz <= out_buf[4];
      result.proj_metric_zz <= out_buf[5];
      result.proj_curv_xx   <= out_buf[6];
      result.proj_curv_xy   <= out_buf[7];
      result.proj_curv_xz   <= out_buf[8];
      result.proj_curv_yy   <= out_buf[9];
      result.proj_curv_yz   <= out_buf[10];
      result.proj_curv_zz   <= out_buf[11];
    end
    if (rst) begin
      state        <= S_IDLE;
      pc           <= 7'd0;
      ld_cnt       <= 4'd0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        pc     <= 7'd0;
        ld_cnt <= 4'd0;
      end
      if (state == S_LOAD) ld_cnt <= ld_cnt + 4'd1;
      if (instr_done) pc <= pc + 7'd1;
      if (state == S_EXEC && cur.op == OP_END) pc <= 7'd0;
      if (state == S_PUSH && push_ok) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/conformal_metric_projection.sv]
// top level: register port, input queue and projection sequencer
// Projects one grid point (symmetric Q16.48 metric and curvature) onto unit
// determinant and removes the curvature trace. A two-entry input queue takes
// new points while the sequencer works, and a result register holds the
// finished point until it is taken. A point is loaded as 12 words, then the
// 43 products and the 63 cube-root steps run on the single 32x32 multiplier
// that the sequencer shares between the products, the divide by three and
// the cube-root search; when |det - 1| is below det_guard_floor the search
// is skipped. det_guard_floor sits at address 0 (64-bit data, low 49 bits
// kept); the user must see that it is written only while the block is idle,
// as the block itself does not enforce it.
module conformal_metric_projection import cmp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  item_t       item,
  input  logic        item_valid,
  output logic        item_ready,
  output result_t     result,
  output logic        result_valid,
  input  logic        result_ready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [GUARD_W-1:0] det_guard_floor;
  logic               guard_sel;
  queue_head_t        head;
  logic               pop;

  // byte offset bits within the 64-bit register are ignored
  assign guard_sel = (paddr[3] == ADDR_GUARD[3]);

  assign pready = 1'b1;
  assign prdata = guard_sel ? {{(64-GUARD_W){1'b0}}, det_guard_floor} : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_guard_floor <= GUARD_W'(281);
    end else if (psel && penable && pwrite && pready && guard_sel) begin
      det_guard_floor <= pwdata[GUARD_W-1:0];
    end
  end

  cmp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .head       (head),
    .pop        (pop)
  );

  cmp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .guard_floor  (det_guard_floor),
    .head         (head),
    .pop          (pop),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

[hdl/cmp_checker.sv]
// port-level checks for the projection block, bound to the top level
`include "conformal_metric_projection_macros.svh"

module cmp_checker import cmp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        item_ready,
  input result_t     result,
  input logic        result_valid,
  input logic        result_ready,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [63:0] pwdata,
  input logic [63:0] prdata,
  input logic        pready
);

  // a stalled result transaction keeps its valid and payload
  `CMP_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid)
  `CMP_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(result))
  // a register write is read back on the next cycle
  `CMP_ASSERT_NEXT(a_guard_readback,
    psel && penable && pwrite && pready && paddr == ADDR_GUARD,
    paddr != ADDR_GUARD || prdata == {15'd0, $past(pwdata[48:0])})
  // reset empties the result side and opens the input side
  `CMP_ASSERT_RST(a_reset_clear, rst, !result_valid && item_ready)

endmodule

bind conformal_metric_projection cmp_checker u_chk (.*);
